FILE: hdl/rohmu_pkg.sv
// ----------------------------------------------------------------------------
// rohmu_pkg
// Shared types and constants of the ray occupancy hit/miss update block.
// ----------------------------------------------------------------------------
package rohmu_pkg;

  // Default grid extent per axis
  localparam int GRID_X_DEF = 32;
  localparam int GRID_Y_DEF = 32;
  localparam int GRID_Z_DEF = 32;

  // Field widths
  localparam int MM_W   = 21;  // millimetre coordinate
  localparam int SIZE_W = 16;  // voxel edge
  localparam int INT_W  = 16;  // intensity
  localparam int IDX_W  = 15;  // linear voxel index on the port
  localparam int CFG_W  = 21;  // config data width
  localparam int CFGA_W = 3;   // config index width
  localparam int CW     = 24;  // signed voxel coordinate
  localparam int DW     = 25;  // signed coordinate difference
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 32;
  localparam int SQ_W   = 48;
  localparam int ISQ_W  = 32;

  // Commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_REL   = 2'd1;
  localparam logic [1:0] CMD_RAY   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Config register indexes
  localparam logic [CFGA_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFGA_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFGA_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFGA_W-1:0] REG_MIN_X    = 3'd3;
  localparam logic [CFGA_W-1:0] REG_MIN_Y    = 3'd4;
  localparam logic [CFGA_W-1:0] REG_MIN_Z    = 3'd5;
  localparam logic [CFGA_W-1:0] REG_VSIZE    = 3'd6;

  localparam logic [SIZE_W-1:0] VSIZE_RESET = 16'd100;

  // Classified work word passed from front to back
  typedef struct packed {
    logic [1:0]            cmd;
    logic [2:0][CW-1:0]    org;    // origin voxel, x at [0]
    logic [2:0][CW-1:0]    endc;   // end voxel, x at [0]
    logic [INT_W-1:0]      inten;
    logic [ISQ_W-1:0]      isq;    // intensity squared
    logic [IDX_W-1:0]      idx;
    logic                  flag;
  } item_t;

  // Statistics of one voxel
  typedef struct packed {
    logic [CNT_W-1:0] hit;
    logic [CNT_W-1:0] miss;
    logic [SUM_W-1:0] isum;
    logic [SQ_W-1:0]  isq;
  } stats_t;

endpackage

FILE: hdl/rohmu_ray_if.sv
// ----------------------------------------------------------------------------
// rohmu_ray_if
// Command word channel into the occupancy block.
// ----------------------------------------------------------------------------
interface rohmu_ray_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic signed [rohmu_pkg::MM_W-1:0] point_x;
  logic signed [rohmu_pkg::MM_W-1:0] point_y;
  logic signed [rohmu_pkg::MM_W-1:0] point_z;
  logic [rohmu_pkg::INT_W-1:0]      intensity;
  logic [rohmu_pkg::IDX_W-1:0]      voxel_index;
  logic                             relevant_flag;

  modport source (output valid, command, point_x, point_y, point_z, intensity,
                  voxel_index, relevant_flag, input ready);
  modport sink (input valid, command, point_x, point_y, point_z, intensity,
                voxel_index, relevant_flag, output ready);
endinterface

FILE: hdl/rohmu_stat_if.sv
// ----------------------------------------------------------------------------
// rohmu_stat_if
// Result word channel out of the occupancy block.
// ----------------------------------------------------------------------------
interface rohmu_stat_if;
  logic                          valid;
  logic                          ready;
  logic [rohmu_pkg::CNT_W-1:0]   hit_count;
  logic [rohmu_pkg::CNT_W-1:0]   miss_count;
  logic [rohmu_pkg::SUM_W-1:0]   intensity_total;
  logic [rohmu_pkg::SQ_W-1:0]    intensity_square_total;
  logic                          is_relevant;

  modport source (output valid, hit_count, miss_count, intensity_total,
                  intensity_square_total, is_relevant, input ready);
  modport sink (input valid, hit_count, miss_count, intensity_total,
                intensity_square_total, is_relevant, output ready);
endinterface

FILE: hdl/ray_occupancy_hit_miss_update.sv
// A ray first has its endpoint coordinates turned into voxels by six bit-serial
//   floor divisions on the shared divider, then is walked voxel by voxel; a relevant
//   voxel walked inside the grid gets a miss update, and a relevant end voxel a hit.
// Reads and relevance writes skip the divider; a clear writes every grid cell in turn.
// The front and the back each take one word at a time, with the queue between them.
// Reset: clears all GRID_X*GRID_Y*GRID_Z cells; no word is accepted until done.
// ----------------------------------------------------------------------------
// ray_occupancy_hit_miss_update
// Ray cast occupancy grid: a front converts endpoints to voxels, a queue
// decouples it from the back, which walks rays and keeps voxel statistics.
// ----------------------------------------------------------------------------
module ray_occupancy_hit_miss_update #(
  parameter int GRID_X = rohmu_pkg::GRID_X_DEF,
  parameter int GRID_Y = rohmu_pkg::GRID_Y_DEF,
  parameter int GRID_Z = rohmu_pkg::GRID_Z_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rohmu_pkg::CFGA_W-1:0]  cfg_index,
  input  logic [rohmu_pkg::CFG_W-1:0]   cfg_data,
  rohmu_ray_if.sink                     ray,
  rohmu_stat_if.source                  stat
);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             init_busy;
  rohmu_pkg::item_t push_item;
  rohmu_pkg::item_t head;

  rohmu_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .hold(init_busy), .ray,
    .push(q_push), .push_item, .q_full
  );

  rohmu_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_item, .pop(q_pop),
    .head, .full(q_full), .empty(q_empty)
  );

  rohmu_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
    .clk, .rst, .head, .empty(q_empty), .pop(q_pop), .init_busy, .stat
  );

  // Queue never overflows or underflows
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("pop from empty queue");
  // No word accepted during the reset clearing pass
  assert property (@(posedge clk) init_busy |-> !ray.ready)
    else $error("word accepted while clearing");
  assert property (@(posedge clk) rst |=> init_busy)
    else $error("reset did not start clearing pass");

endmodule

FILE: hdl/rohmu_front.sv
// ----------------------------------------------------------------------------
// rohmu_front
// Holds the config registers, accepts command words and turns ray endpoints
// into voxel coordinates with a shared bit-serial floor divider.
// ----------------------------------------------------------------------------
module rohmu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rohmu_pkg::CFGA_W-1:0]  cfg_index,
  input  logic [rohmu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          hold,
  rohmu_ray_if.sink                     ray,
  output logic                          push,
  output rohmu_pkg::item_t              push_item,
  input  logic                          q_full
);

  localparam int MM_W   = rohmu_pkg::MM_W;
  localparam int SIZE_W = rohmu_pkg::SIZE_W;
  localparam int CW     = rohmu_pkg::CW;
  localparam int MAG_W  = MM_W;        // |p - min| fits in 21 bits
  localparam int REM_W  = SIZE_W;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_LOAD = 3'd1;
  localparam logic [2:0] F_DIV  = 3'd2;
  localparam logic [2:0] F_FIN  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]               state;
  logic [MM_W-1:0]          origin [3];
  logic [MM_W-1:0]          gmin [3];
  logic [SIZE_W-1:0]        vsize;
  logic [2:0]               k;
  logic [4:0]               cnt;
  logic [MAG_W-1:0]         mag;
  logic [REM_W-1:0]         rem;
  logic                     neg;
  logic [MM_W-1:0]          pt [3];
  rohmu_pkg::item_t         item;

  logic [SIZE_W-1:0]        divisor;
  logic [MM_W-1:0]          src;
  logic [MM_W-1:0]          mn;
  logic signed [MM_W:0]     diff;
  logic [REM_W:0]           trial;
  logic                     take;
  logic [CW-1:0]            qpos;
  logic [CW-1:0]            coord;

  // Zero size counts as one
  assign divisor = (vsize == '0) ? SIZE_W'(1) : vsize;

  // Pick the operand of the current division
  always_comb begin
    case (k)
      3'd0: begin src = origin[0]; mn = gmin[0]; end
      3'd1: begin src = origin[1]; mn = gmin[1]; end
      3'd2: begin src = origin[2]; mn = gmin[2]; end
      3'd3: begin src = pt[0]; mn = gmin[0]; end
      3'd4: begin src = pt[1]; mn = gmin[1]; end
      default: begin src = pt[2]; mn = gmin[2]; end
    endcase
    diff  = (MM_W+1)'($signed(src)) - (MM_W+1)'($signed(mn));
    trial = {rem, mag[MAG_W-1]};
    take  = (trial >= {1'b0, divisor});
    qpos  = CW'(mag);
    coord = neg ? (-qpos - CW'(rem != '0)) : qpos;
  end

  assign ray.ready = (state == F_IDLE) && !hold;
  assign push      = (state == F_PUSH) && !q_full;
  assign push_item = item;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0; origin[1] <= '0; origin[2] <= '0;
      gmin[0] <= '0; gmin[1] <= '0; gmin[2] <= '0;
      vsize <= rohmu_pkg::VSIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rohmu_pkg::REG_ORIGIN_X: origin[0] <= cfg_data;
        rohmu_pkg::REG_ORIGIN_Y: origin[1] <= cfg_data;
        rohmu_pkg::REG_ORIGIN_Z: origin[2] <= cfg_data;
        rohmu_pkg::REG_MIN_X:    gmin[0] <= cfg_data;
        rohmu_pkg::REG_MIN_Y:    gmin[1] <= cfg_data;
        rohmu_pkg::REG_MIN_Z:    gmin[2] <= cfg_data;
        rohmu_pkg::REG_VSIZE:    vsize <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (ray.valid && ray.ready) begin
            state <= (ray.command == rohmu_pkg::CMD_RAY) ? F_LOAD : F_PUSH;
          end
        end
        F_LOAD: state <= F_DIV;
        F_DIV: begin
          if (cnt == '0) begin
            state <= F_FIN;
          end
        end
        F_FIN: state <= (k == 3'd5) ? F_PUSH : F_LOAD;
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath: capture word, run the divider, store coordinates
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        item.cmd   <= ray.command;
        item.inten <= ray.intensity;
        item.isq   <= ray.intensity * ray.intensity;
        item.idx   <= ray.voxel_index;
        item.flag  <= ray.relevant_flag;
        pt[0] <= ray.point_x;
        pt[1] <= ray.point_y;
        pt[2] <= ray.point_z;
        k <= '0;
      end
      F_LOAD: begin
        neg <= diff[MM_W];
        mag <= diff[MM_W] ? MAG_W'(-diff) : MAG_W'(diff);
        rem <= '0;
        cnt <= 5'(MAG_W - 1);
      end
      F_DIV: begin
        rem <= take ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
        mag <= {mag[MAG_W-2:0], take};
        cnt <= cnt - 5'd1;
      end
      F_FIN: begin
        if (k < 3'd3) begin
          item.org[k[1:0]] <= coord;
        end else begin
          item.endc[2'(k - 3'd3)] <= coord;
        end
        k <= k + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/rohmu_fifo.sv
// ----------------------------------------------------------------------------
// rohmu_fifo
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rohmu_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rohmu_pkg::item_t push_item,
  input  logic             pop,
  output rohmu_pkg::item_t head,
  output logic             full,
  output logic             empty
);

  rohmu_pkg::item_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Store word
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hdl/rohmu_back.sv
// ----------------------------------------------------------------------------
// rohmu_back
// Owns the voxel memories, walks rays, updates statistics and drives the
// result register. Also runs the clearing passes.
// ----------------------------------------------------------------------------
module rohmu_back #(
  parameter int GRID_X = rohmu_pkg::GRID_X_DEF,
  parameter int GRID_Y = rohmu_pkg::GRID_Y_DEF,
  parameter int GRID_Z = rohmu_pkg::GRID_Z_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rohmu_pkg::item_t head,
  input  logic             empty,
  output logic             pop,
  output logic             init_busy,
  rohmu_stat_if.source     stat
);

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = rohmu_pkg::CW;
  localparam int DW    = rohmu_pkg::DW;
  localparam int CNT_W = rohmu_pkg::CNT_W;
  localparam int SUM_W = rohmu_pkg::SUM_W;
  localparam int SQ_W  = rohmu_pkg::SQ_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CLR  = 3'd1;
  localparam logic [2:0] B_WALK = 3'd2;
  localparam logic [2:0] B_MRD  = 3'd3;
  localparam logic [2:0] B_HIT  = 3'd4;
  localparam logic [2:0] B_HRD  = 3'd5;
  localparam logic [2:0] B_RD   = 3'd6;
  localparam logic [2:0] B_EMIT = 3'd7;

  rohmu_pkg::stats_t   stats_mem [CELLS];
  logic                rel_mem [CELLS];

  logic [2:0]          state;
  rohmu_pkg::item_t    op;
  logic [2:0][CW-1:0]  cur;
  logic [AW:0]         clr_addr;
  logic                clr_rel;
  rohmu_pkg::stats_t   res;
  logic                res_rel;
  rohmu_pkg::stats_t   rd_stats;
  logic                rd_rel;
  logic                ovalid;

  logic                st_we;
  logic [AW-1:0]       st_wa;
  rohmu_pkg::stats_t   st_wd;
  logic                rl_we;
  logic [AW-1:0]       rl_wa;
  logic                rl_wd;
  logic [AW-1:0]       rd_addr;

  logic signed [DW-1:0] r [3];
  logic [DW-1:0]        a [3];
  logic [1:0]           comp;
  logic [2:0][CW-1:0]   nxt;
  logic                 at_end;
  logic                 nxt_end;
  logic                 head_ok;
  logic                 out_free;
  rohmu_pkg::stats_t    hit_upd;
  logic [SUM_W:0]       sum_ext;
  logic [SQ_W:0]        sq_ext;

  function automatic logic in_grid(input logic [2:0][CW-1:0] c);
    in_grid = !c[0][CW-1] && (c[0] < CW'(GRID_X)) &&
              !c[1][CW-1] && (c[1] < CW'(GRID_Y)) &&
              !c[2][CW-1] && (c[2] < CW'(GRID_Z));
  endfunction

  function automatic logic [AW-1:0] lin(input logic [2:0][CW-1:0] c);
    lin = AW'(c[0][7:0]) + AW'(GRID_X) * (AW'(c[1][7:0]) + AW'(GRID_Y) * AW'(c[2][7:0]));
  endfunction

  assign head_ok  = (32'(head.idx) < 32'(CELLS));
  assign out_free = !ovalid || stat.ready;

  // Pick the axis with the largest remaining distance and step once
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = DW'($signed(op.endc[i])) - DW'($signed(cur[i]));
      a[i] = r[i][DW-1] ? DW'(-r[i]) : DW'(r[i]);
    end
    comp = 2'd0;
    if (a[1] > a[0]) comp = 2'd1;
    if (a[2] > a[comp]) comp = 2'd2;
    nxt = cur;
    nxt[comp] = (r[comp] > 0) ? cur[comp] + CW'(1) : cur[comp] - CW'(1);
    at_end  = (cur == op.endc);
    nxt_end = (nxt == op.endc);
  end

  // Hit update with saturation
  always_comb begin
    hit_upd      = rd_stats;
    hit_upd.hit  = (rd_stats.hit == '1) ? rd_stats.hit : rd_stats.hit + CNT_W'(1);
    sum_ext      = {1'b0, rd_stats.isum} + (SUM_W+1)'(op.inten);
    hit_upd.isum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    sq_ext       = {1'b0, rd_stats.isq} + (SQ_W+1)'(op.isq);
    hit_upd.isq  = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
  end

  // Memory port control
  always_comb begin
    st_we   = 1'b0;
    st_wa   = lin(cur);
    st_wd   = rd_stats;
    rl_we   = 1'b0;
    rl_wa   = AW'(head.idx);
    rl_wd   = head.flag;
    rd_addr = AW'(head.idx);
    pop     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty && !init_busy) begin
          pop   = 1'b1;
          rl_we = (head.cmd == rohmu_pkg::CMD_REL) && head_ok;
        end
      end
      B_CLR: begin
        st_we = 1'b1;
        st_wa = clr_addr[AW-1:0];
        st_wd = '0;
        rl_we = clr_rel;
        rl_wa = clr_addr[AW-1:0];
        rl_wd = 1'b0;
      end
      B_WALK: rd_addr = lin(nxt);
      B_MRD: begin
        st_we = rd_rel && (rd_stats.miss != '1);
        st_wd.miss = rd_stats.miss + CNT_W'(1);
      end
      B_HIT: rd_addr = lin(op.endc);
      B_HRD: begin
        st_we = rd_rel;
        st_wa = lin(op.endc);
        st_wd = hit_upd;
      end
      default: ;
    endcase
  end

  // Memories with registered read
  always_ff @(posedge clk) begin
    if (st_we) stats_mem[st_wa] <= st_wd;
    if (rl_we) rel_mem[rl_wa] <= rl_wd;
    rd_stats <= stats_mem[rd_addr];
    rd_rel   <= rel_mem[rd_addr];
  end

  // Sequence one word at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr_addr  <= '0;
      clr_rel   <= 1'b1;
      init_busy <= 1'b1;
      ovalid    <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded now
      if (ovalid && stat.ready && !(state == B_EMIT && out_free)) ovalid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) begin
            op      <= head;
            cur     <= head.org;
            res     <= '0;
            res_rel <= 1'b0;
            case (head.cmd)
              rohmu_pkg::CMD_CLEAR: begin
                clr_addr <= '0;
                clr_rel  <= 1'b0;
                state    <= B_CLR;
              end
              rohmu_pkg::CMD_RAY:  state <= B_WALK;
              rohmu_pkg::CMD_READ: state <= head_ok ? B_RD : B_EMIT;
              default:             state <= B_EMIT;
            endcase
          end
        end
        B_CLR: begin
          clr_addr <= clr_addr + (AW+1)'(1);
          if (clr_addr == (AW+1)'(CELLS - 1)) begin
            state     <= init_busy ? B_IDLE : B_EMIT;
            init_busy <= 1'b0;
          end
        end
        B_WALK: begin
          if (at_end) begin
            state <= B_HIT;
          end else begin
            cur <= nxt;
            if (nxt_end) state <= B_HIT;
            else if (in_grid(nxt)) state <= B_MRD;
          end
        end
        B_MRD: state <= B_WALK;
        B_HIT: state <= in_grid(op.endc) ? B_HRD : B_EMIT;
        B_HRD: state <= B_EMIT;
        B_RD: begin
          res     <= rd_stats;
          res_rel <= rd_rel;
          state   <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            stat.hit_count              <= res.hit;
            stat.miss_count             <= res.miss;
            stat.intensity_total        <= res.isum;
            stat.intensity_square_total <= res.isq;
            stat.is_relevant            <= res_rel;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign stat.valid = ovalid;

endmodule

FILE: tb/ray_occupancy_hit_miss_update_test.sv
// ----------------------------------------------------------------------------
// ray_occupancy_hit_miss_update_test
// Drives command words into the occupancy block and checks every result word
// against a predictor that keeps its own voxel statistics. A directed table
// runs first, then random phases with several grid and origin settings.
// ----------------------------------------------------------------------------
module ray_occupancy_hit_miss_update_test;

  localparam int NX = 32, NY = 32, NZ = 32;
  localparam int CELLS = NX * NY * NZ;
  localparam int PHASE_ITEMS = 120;

  typedef struct {
    logic [1:0]        cmd;
    int                px, py, pz;
    int                inten;
    int                idx;
    bit                flag;
    bit                typed;   // expect the word passed to send_word
  } cmd_word_t;

  typedef struct {
    bit [rohmu_pkg::CNT_W-1:0] hit;
    bit [rohmu_pkg::CNT_W-1:0] miss;
    bit [rohmu_pkg::SUM_W-1:0] isum;
    bit [rohmu_pkg::SQ_W-1:0]  isq;
    bit                        rel;
  } voxel_stats_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [rohmu_pkg::CFGA_W-1:0] cfg_index = '0;
  logic [rohmu_pkg::CFG_W-1:0] cfg_data = '0;

  rohmu_ray_if ray_ch();
  rohmu_stat_if stat_ch();

  ray_occupancy_hit_miss_update dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ray(ray_ch), .stat(stat_ch)
  );

  always #4 clk = ~clk;

  // Predicted grid state and settings
  bit                         rel_map  [CELLS];
  bit [rohmu_pkg::CNT_W-1:0]  hit_mem  [CELLS];
  bit [rohmu_pkg::CNT_W-1:0]  miss_mem [CELLS];
  bit [rohmu_pkg::SUM_W-1:0]  isum_mem [CELLS];
  bit [rohmu_pkg::SQ_W-1:0]   isq_mem  [CELLS];
  longint          origin_mm [3];
  longint          min_mm [3];
  longint          vsize;

  voxel_stats_t pending_stats[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 0;
  int  hold_cycles = 0;

  function automatic longint floor_div(longint d, longint s);
    longint q;
    q = d / s;
    if ((d % s) != 0 && d < 0) q--;
    return q;
  endfunction

  function automatic longint cell_of(longint c[3]);
    if (c[0] < 0 || c[0] >= NX || c[1] < 0 || c[1] >= NY || c[2] < 0 || c[2] >= NZ)
      return -1;
    return c[0] + NX * (c[1] + NY * c[2]);
  endfunction

  function automatic longint voxel_of(longint mm, int axis);
    longint s;
    s = (vsize == 0) ? 1 : vsize;
    return floor_div(mm - min_mm[axis], s);
  endfunction

  // Walk one ray: miss on every relevant voxel passed, hit on the end voxel if relevant
  function automatic void cast_ray(cmd_word_t w);
    longint cur[3], fin[3], r[3], a[3], pt[3];
    longint i;
    int k, ax;
    longint sq;
    pt[0] = w.px; pt[1] = w.py; pt[2] = w.pz;
    for (k = 0; k < 3; k++) begin
      cur[k] = voxel_of(origin_mm[k], k);
      fin[k] = voxel_of(pt[k], k);
    end
    while (cur != fin) begin
      for (k = 0; k < 3; k++) begin
        r[k] = fin[k] - cur[k];
        a[k] = r[k] < 0 ? -r[k] : r[k];
      end
      ax = 0;
      if (a[1] > a[0]) ax = 1;
      if (a[2] > a[ax]) ax = 2;
      cur[ax] += (r[ax] > 0) ? 1 : -1;
      if (cur == fin) break;
      i = cell_of(cur);
      if (i >= 0 && rel_map[i] && miss_mem[i] != 16'hFFFF) miss_mem[i]++;
    end
    i = cell_of(fin);
    if (i >= 0 && rel_map[i]) begin
      if (hit_mem[i] != 16'hFFFF) hit_mem[i]++;
      sq = longint'(isum_mem[i]) + w.inten;
      isum_mem[i] = (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
      sq = longint'(isq_mem[i]) + longint'(w.inten) * w.inten;
      isq_mem[i] = (sq > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sq[47:0];
    end
  endfunction

  function automatic voxel_stats_t update_grid(cmd_word_t w);
    voxel_stats_t res;
    res = '{default: 0};
    case (w.cmd)
      rohmu_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          hit_mem[i] = 0; miss_mem[i] = 0; isum_mem[i] = 0; isq_mem[i] = 0;
        end
      end
      rohmu_pkg::CMD_REL: if (w.idx < CELLS) rel_map[w.idx] = w.flag;
      rohmu_pkg::CMD_RAY: cast_ray(w);
      rohmu_pkg::CMD_READ: begin
        if (w.idx < CELLS) begin
          res.hit = hit_mem[w.idx];
          res.miss = miss_mem[w.idx];
          res.isum = isum_mem[w.idx];
          res.isq = isq_mem[w.idx];
          res.rel = rel_map[w.idx];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Write one register and mirror it; the caller drops the write enable
  task automatic write_reg(logic [rohmu_pkg::CFGA_W-1:0] ri, longint val);
    cfg_write <= 1;
    cfg_index <= ri;
    cfg_data <= val[rohmu_pkg::CFG_W-1:0];
    @(posedge clk);
    if (ri == rohmu_pkg::REG_VSIZE) vsize = val & 16'hFFFF;
    else if (ri <= rohmu_pkg::REG_ORIGIN_Z) origin_mm[ri] = val;
    else min_mm[ri - rohmu_pkg::REG_MIN_X] = val;
  endtask

  task automatic set_grid(longint ox, longint oy, longint oz, longint mx, longint my,
                          longint mz, longint vs);
    write_reg(rohmu_pkg::REG_ORIGIN_X, ox);
    write_reg(rohmu_pkg::REG_ORIGIN_Y, oy);
    write_reg(rohmu_pkg::REG_ORIGIN_Z, oz);
    write_reg(rohmu_pkg::REG_MIN_X, mx);
    write_reg(rohmu_pkg::REG_MIN_Y, my);
    write_reg(rohmu_pkg::REG_MIN_Z, mz);
    write_reg(rohmu_pkg::REG_VSIZE, vs);
    cfg_write <= 0;
  endtask

  // Offer one word; hold valid until accepted, then maybe go idle
  task automatic send_word(cmd_word_t w, voxel_stats_t typed_exp);
    voxel_stats_t res;
    ray_ch.valid <= 1;
    ray_ch.command <= w.cmd;
    ray_ch.point_x <= w.px;
    ray_ch.point_y <= w.py;
    ray_ch.point_z <= w.pz;
    ray_ch.intensity <= w.inten;
    ray_ch.voxel_index <= w.idx;
    ray_ch.relevant_flag <= w.flag;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    res = update_grid(w);
    pending_stats.insert(pending_stats.size(), w.typed ? typed_exp : res);
    if ($urandom_range(99) < send_idle_pct) begin
      ray_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    ray_ch.valid <= 0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Voxel index near the origin voxel, so rays touch it often
  function automatic int near_index();
    longint c[3];
    longint v;
    for (int k = 0; k < 3; k++) begin
      v = voxel_of(origin_mm[k], k) + $urandom_range(0, 16) - 8;
      c[k] = v < 0 ? 0 : (v >= NX ? NX - 1 : v);
    end
    return int'(cell_of(c));
  endfunction

  function automatic int rand_mm(longint center, int span, bit full);
    longint v;
    if (full) return $urandom_range(0, 2000000) - 1000000;
    v = center + $urandom_range(0, 2 * span) - span;
    if (v > 1000000) v = 1000000;
    if (v < -1000000) v = -1000000;
    return int'(v);
  endfunction

  function automatic cmd_word_t random_word(int span, bit full);
    cmd_word_t w;
    int pick;
    w = '{cmd: rohmu_pkg::CMD_READ, px: 0, py: 0, pz: 0, inten: 0, idx: 0, flag: 0,
          typed: 0};
    pick = $urandom_range(0, 999);
    w.px = rand_mm(origin_mm[0], span, full);
    w.py = rand_mm(origin_mm[1], span, full);
    w.pz = rand_mm(origin_mm[2], span, full);
    case ($urandom_range(0, 5))
      0: w.inten = 16'hFFFF;
      1: w.inten = 0;
      default: w.inten = $urandom_range(0, 65535);
    endcase
    w.idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CELLS - 1) : near_index();
    w.flag = $urandom_range(0, 3) != 0;
    if (pick < 3) w.cmd = rohmu_pkg::CMD_CLEAR;
    else if (pick < 200) w.cmd = rohmu_pkg::CMD_REL;
    else if (pick < 600) w.cmd = rohmu_pkg::CMD_RAY;
    else w.cmd = rohmu_pkg::CMD_READ;
    return w;
  endfunction

  // Receiver: check each result word, stall at random, honor a long hold-off
  always @(posedge clk) begin
    voxel_stats_t exp_w;
    if (!rst && stat_ch.valid && stat_ch.ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result word hit=%0d miss=%0d", $realtime,
                 stat_ch.hit_count, stat_ch.miss_count);
        errors++;
      end else begin
        exp_w = pending_stats.pop_front();
        if (stat_ch.hit_count !== exp_w.hit || stat_ch.miss_count !== exp_w.miss ||
            stat_ch.intensity_total !== exp_w.isum ||
            stat_ch.intensity_square_total !== exp_w.isq ||
            stat_ch.is_relevant !== exp_w.rel) begin
          $display("%0t: mismatch expected hit=%0d miss=%0d sum=%0d sq=%0d rel=%0d",
                   $realtime, exp_w.hit, exp_w.miss, exp_w.isum, exp_w.isq, exp_w.rel);
          $display("%0t:          actual hit=%0d miss=%0d sum=%0d sq=%0d rel=%0d",
                   $realtime, stat_ch.hit_count, stat_ch.miss_count,
                   stat_ch.intensity_total, stat_ch.intensity_square_total,
                   stat_ch.is_relevant);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      stat_ch.ready <= 0;
    end else if (hold_request) begin
      hold_cycles <= 3000;
      stat_ch.ready <= 0;
    end else begin
      stat_ch.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    cmd_word_t table_rows[$];
    voxel_stats_t zero_stats;
    cmd_word_t w;
    int n;
    int span;
    bit full;

    ray_ch.valid = 0;
    ray_ch.command = rohmu_pkg::CMD_READ;
    ray_ch.point_x = 0;
    ray_ch.point_y = 0;
    ray_ch.point_z = 0;
    ray_ch.intensity = 0;
    ray_ch.voxel_index = 0;
    ray_ch.relevant_flag = 0;
    zero_stats = '{default: 0};
    for (int k = 0; k < 3; k++) begin
      origin_mm[k] = 0;
      min_mm[k] = 0;
    end
    vsize = 100;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed table; typed rows expect an all-zero word
    table_rows = '{
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 1},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 32767, 0, 1},
      '{rohmu_pkg::CMD_REL,   0, 0, 0, 0, 0, 1, 1},
      '{rohmu_pkg::CMD_REL,   0, 0, 0, 0, 1, 1, 1},
      '{rohmu_pkg::CMD_REL,   0, 0, 0, 0, 2, 1, 1},
      '{rohmu_pkg::CMD_RAY,   250, 0, 0, 65535, 0, 0, 1},
      '{rohmu_pkg::CMD_RAY,   50, 50, 99, 0, 0, 0, 1},
      '{rohmu_pkg::CMD_RAY,   -250, 0, 0, 1234, 0, 0, 1},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 0},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 1, 0, 0},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 2, 0, 0},
      '{rohmu_pkg::CMD_REL,   0, 0, 0, 0, 32767, 1, 1},
      '{rohmu_pkg::CMD_RAY,   1000000, -1000000, -1000000, 77, 0, 0, 1},
      '{rohmu_pkg::CMD_RAY,   3150, 3150, 3150, 65535, 0, 0, 1},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 32767, 0, 0},
      '{rohmu_pkg::CMD_REL,   0, 0, 0, 0, 0, 0, 1},
      '{rohmu_pkg::CMD_RAY,   0, 0, 0, 9, 0, 0, 1},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 0},
      '{rohmu_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 2, 0, 0},
      '{rohmu_pkg::CMD_READ,  0, 0, 0, 0, 32767, 0, 0}
    };
    foreach (table_rows[i]) send_word(table_rows[i], zero_stats);
    drain();

    // Random phases over several grid settings
    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      full = 0;
      case (ph)
        0: begin set_grid(1600, 1650, 1599, 0, 0, 0, 100); span = 1500; end
        1: begin set_grid(7, 9, 3, 0, -3, 0, 0); span = 20; end
        2: begin
          set_grid(1000000, -1000000, 0, -1000000, -1000000, -1000000, 65535);
          span = 0; full = 1;
        end
        3: begin set_grid(-40, 120, 300, -500, -400, -300, 37); span = 600; end
        4: begin set_grid(-150, -150, 150, 0, -1600, 0, 100); span = 1200; end
        default: ;
      endcase
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        case ((n / 37) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
          3: begin send_idle_pct = 30; recv_stall_pct = 30; end
          default: ;
        endcase
        // Long receiver hold-off while words keep coming
        hold_request <= (ph == 0 && j == 10);
        w = random_word(span, full);
        send_word(w, zero_stats);
        n++;
      end
      hold_request <= 0;
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
